[sv/smic_pkg.sv]
package smic_pkg;

  localparam int unsigned SHADOW_BYTES = 65536;
  localparam int unsigned PAGE_BYTES   = 4096;

  localparam int unsigned SHADOW_AW = $clog2(SHADOW_BYTES);
  localparam int unsigned ROW_AW    = SHADOW_AW - 2;
  localparam int unsigned BANK_AW   = ROW_AW - 1;
  localparam int unsigned PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int unsigned LANES     = 4;
  localparam int unsigned ROW_W     = 2 * LANES;
  localparam int unsigned POS_W     = $clog2(2 * LANES);

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_MARK  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] SZ_1 = 2'd0;
  localparam logic [1:0] SZ_2 = 2'd1;

  localparam logic [1:0] SH_UNALLOC = 2'd0;
  localparam logic [1:0] SH_INIT    = 2'd2;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ALWAYS = 2'd1;
  localparam logic [1:0] MODE_ONCE   = 2'd2;

  localparam logic [1:0] CFG_CHECK_MODE  = 2'd0;
  localparam logic [1:0] CFG_PARTIAL_OK  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_BASE = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [1:0]  size_code;
    logic [31:0] instr_address;
    logic [1:0]  mark_state;
  } item_t;

  typedef struct packed {
    logic       untracked;
    logic       page_cross_bug;
    logic [1:0] found_state;
    logic       report;
    logic       bad_read;
  } result_t;

  typedef struct packed {
    logic              wr;
    logic [ROW_W-1:0]  wr_first;
    logic [ROW_W-1:0]  wr_second;
    logic              set_ip;
    logic              set_done;
  } eval_upd_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ROW_AW-1:0] row;
    logic [ROW_W-1:0]  wr_first;
    logic [ROW_W-1:0]  wr_second;
  } store_req_t;

endpackage

[sv/smic_ram.sv]
module smic_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/smic_store.sv]
module smic_store import smic_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_req_t       req_i,
  output logic [ROW_W-1:0] rd_first_o,
  output logic [ROW_W-1:0] rd_second_o,
  output logic             busy_o
);

  logic               busy_q;
  logic [BANK_AW-1:0] clr_q;
  logic               sel_q;
  logic [BANK_AW-1:0] even_addr, odd_addr;
  logic [BANK_AW-1:0] even_wa, odd_wa;
  logic               even_we, odd_we;
  logic [ROW_W-1:0]   even_wd, odd_wd, even_rd, odd_rd;

  // row r and row r+1 always sit in different banks
  assign even_addr = req_i.row[ROW_AW-1:1] + BANK_AW'(req_i.row[0]);
  assign odd_addr  = req_i.row[ROW_AW-1:1];

  always_comb begin
    if (busy_q) begin
      even_we = 1'b1;
      odd_we  = 1'b1;
      even_wa = clr_q;
      odd_wa  = clr_q;
      even_wd = '0;
      odd_wd  = '0;
    end else begin
      even_we = req_i.wr;
      odd_we  = req_i.wr;
      even_wa = even_addr;
      odd_wa  = odd_addr;
      even_wd = req_i.row[0] ? req_i.wr_second : req_i.wr_first;
      odd_wd  = req_i.row[0] ? req_i.wr_first : req_i.wr_second;
    end
  end

  smic_ram #(.AW(BANK_AW), .DW(ROW_W)) u_even (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (even_wa),
    .wdata_i (even_wd),
    .re_i    (req_i.rd && !busy_q),
    .raddr_i (even_addr),
    .rdata_o (even_rd)
  );

  smic_ram #(.AW(BANK_AW), .DW(ROW_W)) u_odd (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (odd_wa),
    .wdata_i (odd_wd),
    .re_i    (req_i.rd && !busy_q),
    .raddr_i (odd_addr),
    .rdata_o (odd_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (&clr_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      sel_q <= req_i.row[0];
    end
  end

  assign rd_first_o  = sel_q ? odd_rd : even_rd;
  assign rd_second_o = sel_q ? even_rd : odd_rd;
  assign busy_o      = busy_q;

endmodule

[sv/smic_eval.sv]
module smic_eval import smic_pkg::*; (
  input  item_t            item_i,
  input  logic [1:0]       check_mode_i,
  input  logic             partial_ok_i,
  input  logic [31:0]      window_base_i,
  input  logic [31:0]      last_ip_i,
  input  logic             oneshot_done_i,
  input  logic [ROW_W-1:0] rd_first_i,
  input  logic [ROW_W-1:0] rd_second_i,
  output result_t          res_o,
  output eval_upd_t        upd_o
);

  logic [31:0]      off;
  logic             tracked;
  logic [LANES-1:0] span;
  logic [1:0]       last;
  logic [PAGE_BITS:0] page_sum;
  logic             spans_page;
  logic [1:0]       view [2*LANES];
  logic [1:0]       found;
  logic [POS_W-1:0] pos;
  logic [1:0]       wval;
  logic             bad;
  logic             active;

  always_comb begin
    off     = item_i.address - window_base_i;
    tracked = (off[31:SHADOW_AW] == '0);

    case (item_i.size_code)
      SZ_1: begin
        span = 4'b0001;
        last = 2'd0;
      end
      SZ_2: begin
        span = 4'b0011;
        last = 2'd1;
      end
      default: begin
        span = 4'b1111;
        last = 2'd3;
      end
    endcase

    // carry out of the in-page offset means the access spans two pages
    page_sum   = {1'b0, item_i.address[PAGE_BITS-1:0]} + (PAGE_BITS+1)'(last);
    spans_page = page_sum[PAGE_BITS];

    for (int i = 0; i < LANES; i++) begin
      view[i]         = rd_first_i[2*i +: 2];
      view[i + LANES] = rd_second_i[2*i +: 2];
    end

    // scan bytes low to high so the highest matching byte wins
    pos   = POS_W'(off[1:0]);
    found = view[pos];
    for (int k = 0; k < LANES; k++) begin
      pos = POS_W'(off[1:0]) + POS_W'(k);
      if (span[k] && (partial_ok_i ? (view[pos] == SH_INIT) : (view[pos] != SH_INIT))) begin
        found = view[pos];
      end
    end

    bad    = (found != SH_INIT);
    active = (check_mode_i == MODE_ALWAYS) ||
             ((check_mode_i == MODE_ONCE) && !oneshot_done_i);
    wval   = (item_i.action == ACT_MARK) ? item_i.mark_state : SH_INIT;

    res_o = '0;
    upd_o = '0;
    if (item_i.action != ACT_NONE) begin
      if (!tracked) begin
        res_o.untracked = 1'b1;
      end else if (item_i.action == ACT_MARK) begin
        upd_o.wr = 1'b1;
      end else if (spans_page) begin
        res_o.page_cross_bug = 1'b1;
      end else if (item_i.action == ACT_WRITE) begin
        upd_o.wr = 1'b1;
      end else begin
        res_o.found_state = found;
        if (bad) begin
          res_o.bad_read = 1'b1;
          res_o.report   = active && (item_i.instr_address != last_ip_i);
          upd_o.wr       = 1'b1;
          upd_o.set_ip   = res_o.report;
          upd_o.set_done = (check_mode_i == MODE_ONCE) && !oneshot_done_i;
        end
      end
    end

    // merge the new byte states into both rows
    for (int k = 0; k < LANES; k++) begin
      pos = POS_W'(off[1:0]) + POS_W'(k);
      if (span[k]) begin
        view[pos] = wval;
      end
    end
    for (int i = 0; i < LANES; i++) begin
      upd_o.wr_first[2*i +: 2]  = view[i];
      upd_o.wr_second[2*i +: 2] = view[i + LANES];
    end
  end

endmodule

[sv/shadow_memory_init_checker_top.sv]
// channel   direction  handshake              payload
// in        input      in_valid_i/in_ready_o    action, address, size_code, instr_address,
//                                               mark_state
// out       output     out_valid_o/out_ready_i  untracked, page_cross_bug, found_state,
//                                               report, bad_read
// cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// each request has two steps: on acceptance the two shadow rows it may touch are read, then
// ST_EXEC updates them and loads the result register; one request is in flight at a time
// after reset the shadow banks are swept to unallocated, one row pair per cycle, with
// in_ready_o low; configuration writes are taken at any time
// a full result register that is not taken holds the update cycle until it drains
module shadow_memory_init_checker_top import smic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [1:0]  size_code_i,
  input  logic [31:0] instr_address_i,
  input  logic [1:0]  mark_state_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        untracked_o,
  output logic        page_cross_bug_o,
  output logic [1:0]  found_state_o,
  output logic        report_o,
  output logic        bad_read_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_q;
  item_t            item_q;
  result_t          res_q;
  logic             out_valid_q;
  logic [1:0]       check_mode_q;
  logic             partial_ok_q;
  logic [31:0]      window_base_q;
  logic [31:0]      last_ip_q;
  logic             oneshot_done_q;

  logic             in_acc;
  logic             cfg_acc;
  logic             go;
  logic [31:0]      off_in, off_item;
  logic             clr_busy;
  logic [ROW_W-1:0] rd_first, rd_second;
  store_req_t       req;
  result_t          res;
  eval_upd_t        upd;

  assign in_ready_o  = (state_q == ST_IDLE) && !clr_busy;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign go          = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  assign off_in   = address_i - window_base_q;
  assign off_item = item_q.address - window_base_q;

  always_comb begin
    req           = '0;
    req.rd        = in_acc;
    req.row       = (state_q == ST_IDLE) ? off_in[SHADOW_AW-1:2] : off_item[SHADOW_AW-1:2];
    req.wr        = go && upd.wr;
    req.wr_first  = upd.wr_first;
    req.wr_second = upd.wr_second;
  end

  smic_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rd_first_o  (rd_first),
    .rd_second_o (rd_second),
    .busy_o      (clr_busy)
  );

  smic_eval u_eval (
    .item_i         (item_q),
    .check_mode_i   (check_mode_q),
    .partial_ok_i   (partial_ok_q),
    .window_base_i  (window_base_q),
    .last_ip_i      (last_ip_q),
    .oneshot_done_i (oneshot_done_q),
    .rd_first_i     (rd_first),
    .rd_second_i    (rd_second),
    .res_o          (res),
    .upd_o          (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_q    <= 1'b0;
      check_mode_q   <= MODE_ALWAYS;
      partial_ok_q   <= 1'b0;
      window_base_q  <= '0;
      last_ip_q      <= '0;
      oneshot_done_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            if (upd.set_ip) begin
              last_ip_q <= item_q.instr_address;
            end
            if (upd.set_done) begin
              oneshot_done_q <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_CHECK_MODE: begin
            check_mode_q   <= cfg_data_i[1:0];
            oneshot_done_q <= 1'b0;
          end
          CFG_PARTIAL_OK:  partial_ok_q  <= cfg_data_i[0];
          CFG_WINDOW_BASE: window_base_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.action        <= action_i;
      item_q.address       <= address_i;
      item_q.size_code     <= size_code_i;
      item_q.instr_address <= instr_address_i;
      item_q.mark_state    <= mark_state_i;
    end
    if (go) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign untracked_o      = res_q.untracked;
  assign page_cross_bug_o = res_q.page_cross_bug;
  assign found_state_o    = res_q.found_state;
  assign report_o         = res_q.report;
  assign bad_read_o       = res_q.bad_read;

endmodule
